FILE: sv/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

    // Result status codes
    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_NOT_ARP   = 4'd2,
        ST_BAD_HTYPE = 4'd3,
        ST_BAD_PTYPE = 4'd4,
        ST_BAD_SIZES = 4'd5,
        ST_NIC_DOWN  = 4'd6,
        ST_EMPTY     = 4'd7,
        ST_NO_LOCAL  = 4'd8,
        ST_NOT_FOUND = 4'd9
    } status_t;

    // Action codes
    localparam logic [1:0] ACT_FRAME   = 2'd0;
    localparam logic [1:0] ACT_LOOKUP  = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_REQUEST = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_LOCAL_IP       = 2'd0;
    localparam logic [1:0] CFG_LOCAL_IP_VALID = 2'd1;
    localparam logic [1:0] CFG_LOCAL_MAC      = 2'd2;
    localparam logic [1:0] CFG_NIC_READY      = 2'd3;

    // Configuration reset values
    localparam logic [31:0] LOCAL_IP_RESET = 32'h0A00_020F;

    // ARP header constants
    localparam logic [10:0] MIN_FRAME_LEN  = 11'd42;
    localparam logic [15:0] ETYPE_ARP      = 16'h0806;
    localparam logic [15:0] HTYPE_ETHER    = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
    localparam logic [15:0] SIZES_ETH_IPV4 = 16'h0604;
    localparam logic [15:0] RX_OP_REQUEST  = 16'h0001;
    localparam logic [15:0] RX_OP_REPLY    = 16'h0002;

    // Transmitted operation codes
    localparam logic [1:0] TX_OP_REQUEST = 2'd1;
    localparam logic [1:0] TX_OP_REPLY   = 2'd2;

    localparam logic [47:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

endpackage

`default_nettype wire

FILE: sv/arp_responder_with_cache_unit.sv
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_stall     action, frame_length ... entry_index
// output    out_valid / out_stall   status, send_frame ... valid_entry_count
// config    cfg_we                  cfg_index, cfg_data
//
// One request at a time. Frame checks, requests and empty-cache cases are settled
// in the decode state, a read passes through a fetch state, and a cache scan
// (frame learn, lookup) reads one slot per cycle behind the registered memory
// read; a hit ends the scan early.
// Valid entries always form a prefix of the slots, so a fill count replaces
// per-entry valid bits and no clearing pass follows reset.
// The finished result sits in an output register; the next request is taken
// in the cycle after it is loaded, also while it waits on out_stall.
module arp_responder_with_cache_unit #(
    parameter int CACHE_ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [10:0] frame_length,
    input  wire logic [15:0] ether_type,
    input  wire logic [31:0] type_pair,
    input  wire logic [15:0] size_pair,
    input  wire logic [15:0] opcode,
    input  wire logic [47:0] src_mac,
    input  wire logic [31:0] src_ip,
    input  wire logic [31:0] tgt_ip,
    input  wire logic [31:0] query_ip,
    input  wire logic [7:0]  entry_index,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       status,
    output logic             send_frame,
    output logic [47:0]      tx_dst_mac,
    output logic [1:0]       tx_opcode,
    output logic [47:0]      tx_tgt_mac,
    output logic [31:0]      tx_tgt_ip,
    output logic [31:0]      found_ip,
    output logic [47:0]      found_mac,
    output logic [8:0]       valid_entry_count
);

    localparam int AW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [8:0]    COUNT_FULL = 9'(CACHE_ENTRIES);
    localparam logic [AW-1:0] PTR_LAST   = AW'(CACHE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FETCH,
        S_FINISH
    } state_t;

    // Configuration registers
    logic [31:0] local_ip_reg;
    logic        local_ip_valid_reg;
    logic [47:0] local_mac_reg;
    logic        nic_ready_reg;

    // Entry memory: {ip, mac}
    logic [79:0]   mem [CACHE_ENTRIES];
    logic [79:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;

    state_t state_reg, state_next;

    // Latched request
    logic [1:0]  act_reg,   act_next;
    logic [10:0] len_reg,   len_next;
    logic [15:0] etype_reg, etype_next;
    logic [31:0] tpair_reg, tpair_next;
    logic [15:0] spair_reg, spair_next;
    logic [15:0] op_reg,    op_next;
    logic [47:0] smac_reg,  smac_next;
    logic [31:0] sip_reg,   sip_next;
    logic [31:0] tip_reg,   tip_next;
    logic [31:0] qip_reg,   qip_next;
    logic [7:0]  idx_reg,   idx_next;

    // Scan and cache bookkeeping
    logic [8:0]    iss_reg,     iss_next;
    logic          chk_vld_reg, chk_vld_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic [8:0]    count_reg,   count_next;
    logic [AW-1:0] ptr_reg,     ptr_next;

    // Result being built
    arpc_pkg::status_t res_status_reg, res_status_next;
    logic        res_send_reg, res_send_next;
    logic [47:0] res_dst_reg,  res_dst_next;
    logic [1:0]  res_op_reg,   res_op_next;
    logic [47:0] res_tmac_reg, res_tmac_next;
    logic [31:0] res_tip_reg,  res_tip_next;
    logic [31:0] res_fip_reg,  res_fip_next;
    logic [47:0] res_fmac_reg, res_fmac_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  status_reg,    status_next;
    logic        send_reg,      send_next;
    logic [47:0] dst_reg,       dst_next;
    logic [1:0]  txop_reg,      txop_next;
    logic [47:0] tmac_reg,      tmac_next;
    logic [31:0] ttip_reg,      ttip_next;
    logic [31:0] fip_reg,       fip_next;
    logic [47:0] fmac_reg,      fmac_next;
    logic [8:0]  cnt_out_reg,   cnt_out_next;

    logic [31:0] scan_key;
    logic        scan_hit;
    logic        scan_done;
    logic        learn_do;
    logic        learn_hit;
    logic        reply_due;

    assign in_stall          = (state_reg != S_IDLE);
    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign send_frame        = send_reg;
    assign tx_dst_mac        = dst_reg;
    assign tx_opcode         = txop_reg;
    assign tx_tgt_mac        = tmac_reg;
    assign tx_tgt_ip         = ttip_reg;
    assign found_ip          = fip_reg;
    assign found_mac         = fmac_reg;
    assign valid_entry_count = cnt_out_reg;

    // Compare the returning entry against the key
    assign scan_key  = (act_reg == arpc_pkg::ACT_FRAME) ? sip_reg : qip_reg;
    assign scan_hit  = chk_vld_reg && (rd_data_reg[79:48] == scan_key);
    assign scan_done = (iss_reg == count_reg);

    // A request aimed at our address calls for a reply
    assign reply_due = (op_reg == arpc_pkg::RX_OP_REQUEST) && local_ip_valid_reg
                       && (tip_reg == local_ip_reg);

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= {sip_reg, smac_reg};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        len_next        = len_reg;
        etype_next      = etype_reg;
        tpair_next      = tpair_reg;
        spair_next      = spair_reg;
        op_next         = op_reg;
        smac_next       = smac_reg;
        sip_next        = sip_reg;
        tip_next        = tip_reg;
        qip_next        = qip_reg;
        idx_next        = idx_reg;
        iss_next        = iss_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_status_next = res_status_reg;
        res_send_next   = res_send_reg;
        res_dst_next    = res_dst_reg;
        res_op_next     = res_op_reg;
        res_tmac_next   = res_tmac_reg;
        res_tip_next    = res_tip_reg;
        res_fip_next    = res_fip_reg;
        res_fmac_next   = res_fmac_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        send_next       = send_reg;
        dst_next        = dst_reg;
        txop_next       = txop_reg;
        tmac_next       = tmac_reg;
        ttip_next       = ttip_reg;
        fip_next        = fip_reg;
        fmac_next       = fmac_reg;
        cnt_out_next    = cnt_out_reg;
        rd_addr         = iss_reg[AW-1:0];
        learn_do        = 1'b0;
        learn_hit       = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = ptr_reg;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next   = action;
                    len_next   = frame_length;
                    etype_next = ether_type;
                    tpair_next = type_pair;
                    spair_next = size_pair;
                    op_next    = opcode;
                    smac_next  = src_mac;
                    sip_next   = src_ip;
                    tip_next   = tgt_ip;
                    qip_next   = query_ip;
                    idx_next   = entry_index;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_status_next = arpc_pkg::ST_OK;
                res_send_next   = 1'b0;
                res_dst_next    = '0;
                res_op_next     = '0;
                res_tmac_next   = '0;
                res_tip_next    = '0;
                res_fip_next    = '0;
                res_fmac_next   = '0;
                iss_next        = '0;
                chk_vld_next    = 1'b0;
                state_next      = S_FINISH;
                unique case (act_reg)
                    arpc_pkg::ACT_FRAME:
                    begin
                        priority if (len_reg < arpc_pkg::MIN_FRAME_LEN)
                        begin
                            res_status_next = arpc_pkg::ST_SHORT;
                        end
                        else if (etype_reg != arpc_pkg::ETYPE_ARP)
                        begin
                            res_status_next = arpc_pkg::ST_NOT_ARP;
                        end
                        else if (tpair_reg[31:16] != arpc_pkg::HTYPE_ETHER)
                        begin
                            res_status_next = arpc_pkg::ST_BAD_HTYPE;
                        end
                        else if (tpair_reg[15:0] != arpc_pkg::PTYPE_IPV4)
                        begin
                            res_status_next = arpc_pkg::ST_BAD_PTYPE;
                        end
                        else if (spair_reg != arpc_pkg::SIZES_ETH_IPV4)
                        begin
                            res_status_next = arpc_pkg::ST_BAD_SIZES;
                        end
                        else if (count_reg == '0)
                        begin
                            learn_do = 1'b1;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end

                    arpc_pkg::ACT_LOOKUP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = arpc_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end

                    arpc_pkg::ACT_READ:
                    begin
                        priority if (count_reg == '0)
                        begin
                            res_status_next = arpc_pkg::ST_EMPTY;
                        end
                        else if ({1'b0, idx_reg} < count_reg)
                        begin
                            rd_addr    = idx_reg[AW-1:0];
                            state_next = S_FETCH;
                        end
                        else
                        begin
                            res_status_next = arpc_pkg::ST_NOT_FOUND;
                        end
                    end

                    arpc_pkg::ACT_REQUEST:
                    begin
                        priority if (!nic_ready_reg)
                        begin
                            res_status_next = arpc_pkg::ST_NIC_DOWN;
                        end
                        else if (!local_ip_valid_reg)
                        begin
                            res_status_next = arpc_pkg::ST_NO_LOCAL;
                        end
                        else
                        begin
                            res_send_next = 1'b1;
                            res_dst_next  = arpc_pkg::MAC_BROADCAST;
                            res_op_next   = arpc_pkg::TX_OP_REQUEST;
                            res_tmac_next = '0;
                            res_tip_next  = qip_reg;
                        end
                    end
                endcase
            end

            S_SCAN:
            begin
                // Issue the next slot read
                if (iss_reg < count_reg)
                begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = iss_reg[AW-1:0];
                    iss_next     = iss_reg + 9'd1;
                end
                else
                begin
                    chk_vld_next = 1'b0;
                end

                // Stop on a match or after the last valid slot
                if (scan_hit || scan_done)
                begin
                    state_next = S_FINISH;
                    if (act_reg == arpc_pkg::ACT_FRAME)
                    begin
                        learn_do  = 1'b1;
                        learn_hit = scan_hit;
                    end
                    else if (scan_hit)
                    begin
                        res_status_next = arpc_pkg::ST_OK;
                        res_fmac_next   = rd_data_reg[47:0];
                    end
                    else
                    begin
                        res_status_next = arpc_pkg::ST_NOT_FOUND;
                    end
                end
            end

            S_FETCH:
            begin
                res_status_next = arpc_pkg::ST_OK;
                res_fip_next    = rd_data_reg[79:48];
                res_fmac_next   = rd_data_reg[47:0];
                state_next      = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    send_next      = res_send_reg;
                    dst_next       = res_dst_reg;
                    txop_next      = res_op_reg;
                    tmac_next      = res_tmac_reg;
                    ttip_next      = res_tip_reg;
                    fip_next       = res_fip_reg;
                    fmac_next      = res_fmac_reg;
                    cnt_out_next   = count_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase

        // Learn the sender: update the matching slot or replace round-robin, and reply if due
        if (learn_do)
        begin
            mem_we = 1'b1;
            if (learn_hit)
            begin
                mem_wa = chk_idx_reg;
            end
            else
            begin
                mem_wa   = ptr_reg;
                ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + AW'(1);
                if (count_reg != COUNT_FULL)
                begin
                    count_next = count_reg + 9'd1;
                end
            end

            if (reply_due)
            begin
                if (!nic_ready_reg)
                begin
                    res_status_next = arpc_pkg::ST_NIC_DOWN;
                end
                else
                begin
                    res_send_next = 1'b1;
                    res_dst_next  = smac_reg;
                    res_op_next   = arpc_pkg::TX_OP_REPLY;
                    res_tmac_next = smac_reg;
                    res_tip_next  = sip_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg       <= arpc_pkg::LOCAL_IP_RESET;
            local_ip_valid_reg <= 1'b1;
            local_mac_reg      <= '0;
            nic_ready_reg      <= 1'b0;
            state_reg          <= S_IDLE;
            act_reg            <= '0;
            len_reg            <= '0;
            etype_reg          <= '0;
            tpair_reg          <= '0;
            spair_reg          <= '0;
            op_reg             <= '0;
            smac_reg           <= '0;
            sip_reg            <= '0;
            tip_reg            <= '0;
            qip_reg            <= '0;
            idx_reg            <= '0;
            iss_reg            <= '0;
            chk_vld_reg        <= 1'b0;
            chk_idx_reg        <= '0;
            count_reg          <= '0;
            ptr_reg            <= '0;
            res_status_reg     <= arpc_pkg::ST_OK;
            res_send_reg       <= 1'b0;
            res_dst_reg        <= '0;
            res_op_reg         <= '0;
            res_tmac_reg       <= '0;
            res_tip_reg        <= '0;
            res_fip_reg        <= '0;
            res_fmac_reg       <= '0;
            out_valid_reg      <= 1'b0;
            status_reg         <= '0;
            send_reg           <= 1'b0;
            dst_reg            <= '0;
            txop_reg           <= '0;
            tmac_reg           <= '0;
            ttip_reg           <= '0;
            fip_reg            <= '0;
            fmac_reg           <= '0;
            cnt_out_reg        <= '0;
        end
        else
        begin
            // Configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    arpc_pkg::CFG_LOCAL_IP:       local_ip_reg       <= cfg_data[31:0];
                    arpc_pkg::CFG_LOCAL_IP_VALID: local_ip_valid_reg <= cfg_data[0];
                    arpc_pkg::CFG_LOCAL_MAC:      local_mac_reg      <= cfg_data;
                    arpc_pkg::CFG_NIC_READY:      nic_ready_reg      <= cfg_data[0];
                endcase
            end
            state_reg      <= state_next;
            act_reg        <= act_next;
            len_reg        <= len_next;
            etype_reg      <= etype_next;
            tpair_reg      <= tpair_next;
            spair_reg      <= spair_next;
            op_reg         <= op_next;
            smac_reg       <= smac_next;
            sip_reg        <= sip_next;
            tip_reg        <= tip_next;
            qip_reg        <= qip_next;
            idx_reg        <= idx_next;
            iss_reg        <= iss_next;
            chk_vld_reg    <= chk_vld_next;
            chk_idx_reg    <= chk_idx_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            res_status_reg <= res_status_next;
            res_send_reg   <= res_send_next;
            res_dst_reg    <= res_dst_next;
            res_op_reg     <= res_op_next;
            res_tmac_reg   <= res_tmac_next;
            res_tip_reg    <= res_tip_next;
            res_fip_reg    <= res_fip_next;
            res_fmac_reg   <= res_fmac_next;
            out_valid_reg  <= out_valid_next;
            status_reg     <= status_next;
            send_reg       <= send_next;
            dst_reg        <= dst_next;
            txop_reg       <= txop_next;
            tmac_reg       <= tmac_next;
            ttip_reg       <= ttip_next;
            fip_reg        <= fip_next;
            fmac_reg       <= fmac_next;
            cnt_out_reg    <= cnt_out_next;
        end
    end

    // Own MAC is stored but neither used nor output; fold it into nothing here
    logic unused_mac;
    assign unused_mac = ^local_mac_reg;

endmodule

`default_nettype wire

FILE: verif/arp_cache_checker.sv
module arp_cache_checker #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic [10:0] frame_length,
    input  logic [15:0] ether_type,
    input  logic [31:0] type_pair,
    input  logic [15:0] size_pair,
    input  logic [15:0] opcode,
    input  logic [47:0] src_mac,
    input  logic [31:0] src_ip,
    input  logic [31:0] tgt_ip,
    input  logic [31:0] query_ip,
    input  logic [7:0]  entry_index,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  status,
    input  logic        send_frame,
    input  logic [47:0] tx_dst_mac,
    input  logic [1:0]  tx_opcode,
    input  logic [47:0] tx_tgt_mac,
    input  logic [31:0] tx_tgt_ip,
    input  logic [31:0] found_ip,
    input  logic [47:0] found_mac,
    input  logic [8:0]  valid_entry_count,

    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        arpc_pkg::status_t status;
        logic        send_frame;
        logic [47:0] dst_mac;
        logic [1:0]  tx_op;
        logic [47:0] tgt_mac;
        logic [31:0] tgt_ip;
        logic [31:0] hit_ip;
        logic [47:0] hit_mac;
        logic [8:0]  count;
    } arp_result_t;

    // Register copies
    logic [31:0] own_ip;
    logic        own_ip_ok;
    logic [47:0] own_mac;
    logic        link_up;

    // Address cache copy
    logic        slot_used [CACHE_ENTRIES];
    logic [31:0] slot_ip   [CACHE_ENTRIES];
    logic [47:0] slot_mac  [CACHE_ENTRIES];
    int unsigned next_slot;

    arp_result_t reply_q [$];
    int          fail_count;
    int          result_num;

    function automatic int unsigned used_slots();
        int unsigned n;
        n = 0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
            if (slot_used[i])
                n++;
        return n;
    endfunction

    // Refresh a matching entry, else overwrite the round-robin slot
    function automatic void learn_sender(logic [31:0] ip, logic [47:0] mac);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (!hit && slot_used[i] && slot_ip[i] == ip) begin
                slot_mac[i] = mac;
                hit = 1'b1;
            end
        end
        if (!hit) begin
            slot_used[next_slot] = 1'b1;
            slot_ip[next_slot]   = ip;
            slot_mac[next_slot]  = mac;
            next_slot = (next_slot + 1) % CACHE_ENTRIES;
        end
    endfunction

    function automatic arp_result_t predict_result();
        arp_result_t r;
        int unsigned seen;
        r = '0;
        r.status = arpc_pkg::ST_OK;
        case (action)
            arpc_pkg::ACT_FRAME: begin
                if (frame_length < arpc_pkg::MIN_FRAME_LEN)
                    r.status = arpc_pkg::ST_SHORT;
                else if (ether_type != arpc_pkg::ETYPE_ARP)
                    r.status = arpc_pkg::ST_NOT_ARP;
                else if (type_pair[31:16] != arpc_pkg::HTYPE_ETHER)
                    r.status = arpc_pkg::ST_BAD_HTYPE;
                else if (type_pair[15:0] != arpc_pkg::PTYPE_IPV4)
                    r.status = arpc_pkg::ST_BAD_PTYPE;
                else if (size_pair != arpc_pkg::SIZES_ETH_IPV4)
                    r.status = arpc_pkg::ST_BAD_SIZES;
                else begin
                    learn_sender(src_ip, src_mac);
                    // answer only a request aimed at our own address
                    if (opcode == arpc_pkg::RX_OP_REQUEST && own_ip_ok
                        && tgt_ip == own_ip) begin
                        if (!link_up)
                            r.status = arpc_pkg::ST_NIC_DOWN;
                        else begin
                            r.send_frame = 1'b1;
                            r.dst_mac    = src_mac;
                            r.tx_op      = arpc_pkg::TX_OP_REPLY;
                            r.tgt_mac    = src_mac;
                            r.tgt_ip     = src_ip;
                        end
                    end
                end
            end
            arpc_pkg::ACT_LOOKUP: begin
                if (used_slots() == 0)
                    r.status = arpc_pkg::ST_EMPTY;
                else begin
                    r.status = arpc_pkg::ST_NOT_FOUND;
                    for (int i = 0; i < CACHE_ENTRIES; i++) begin
                        if (r.status != arpc_pkg::ST_OK && slot_used[i]
                            && slot_ip[i] == query_ip) begin
                            r.status  = arpc_pkg::ST_OK;
                            r.hit_mac = slot_mac[i];
                        end
                    end
                end
            end
            arpc_pkg::ACT_READ: begin
                if (used_slots() == 0)
                    r.status = arpc_pkg::ST_EMPTY;
                else begin
                    seen = 0;
                    r.status = arpc_pkg::ST_NOT_FOUND;
                    for (int i = 0; i < CACHE_ENTRIES; i++) begin
                        if (r.status != arpc_pkg::ST_OK && slot_used[i]) begin
                            if (seen == entry_index) begin
                                r.status  = arpc_pkg::ST_OK;
                                r.hit_ip  = slot_ip[i];
                                r.hit_mac = slot_mac[i];
                            end
                            seen++;
                        end
                    end
                end
            end
            default: begin
                if (!link_up)
                    r.status = arpc_pkg::ST_NIC_DOWN;
                else if (!own_ip_ok)
                    r.status = arpc_pkg::ST_NO_LOCAL;
                else begin
                    r.send_frame = 1'b1;
                    r.dst_mac    = arpc_pkg::MAC_BROADCAST;
                    r.tx_op      = arpc_pkg::TX_OP_REQUEST;
                    r.tgt_ip     = query_ip;
                end
            end
        endcase
        r.count = 9'(used_slots());
        return r;
    endfunction

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                         result_num, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        arp_result_t want;
        if (!rst_n) begin
            own_ip    = arpc_pkg::LOCAL_IP_RESET;
            own_ip_ok = 1'b1;
            own_mac   = '0;
            link_up   = 1'b0;
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
                slot_used[i] = 1'b0;
                slot_ip[i]   = '0;
                slot_mac[i]  = '0;
            end
            next_slot  = 0;
            fail_count = 0;
            result_num = 0;
            reply_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            // track register writes
            if (cfg_we) begin
                case (cfg_index)
                    arpc_pkg::CFG_LOCAL_IP:       own_ip    = cfg_data[31:0];
                    arpc_pkg::CFG_LOCAL_IP_VALID: own_ip_ok = cfg_data[0];
                    arpc_pkg::CFG_LOCAL_MAC:      own_mac   = cfg_data;
                    default:                      link_up   = cfg_data[0];
                endcase
            end

            // compare a delivered result against the oldest prediction
            if (out_valid && !out_stall) begin
                if (reply_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("MISMATCH result %0d arrived with no request pending, status %0d",
                                 result_num, status);
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", want.status, status);
                    check_field("send_frame", want.send_frame, send_frame);
                    check_field("tx_dst_mac", want.dst_mac, tx_dst_mac);
                    check_field("tx_opcode", want.tx_op, tx_opcode);
                    check_field("tx_tgt_mac", want.tgt_mac, tx_tgt_mac);
                    check_field("tx_tgt_ip", want.tgt_ip, tx_tgt_ip);
                    check_field("found_ip", want.hit_ip, found_ip);
                    check_field("found_mac", want.hit_mac, found_mac);
                    check_field("valid_entry_count", want.count, valid_entry_count);
                end
                result_num++;
            end

            // predict each accepted request
            if (in_valid && !in_stall)
                reply_q.push_back(predict_result());

            mismatches  <= fail_count;
            outstanding <= reply_q.size();
        end
    end

endmodule

FILE: verif/tb_arp_responder_with_cache_unit.sv
module tb_arp_responder_with_cache_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 25;
    localparam int PHASE_ITEMS    = 250;
    localparam int POOL_SIZE      = 24;

    typedef struct packed {
        logic [1:0]  action;
        logic [10:0] frame_length;
        logic [15:0] ether_type;
        logic [31:0] type_pair;
        logic [15:0] size_pair;
        logic [15:0] opcode;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] tgt_ip;
        logic [31:0] query_ip;
        logic [7:0]  entry_index;
    } arp_item_t;

    logic        clk;
    logic        rst_n = 1'b0;

    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [47:0] cfg_data  = '0;

    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [1:0]  action       = '0;
    logic [10:0] frame_length = '0;
    logic [15:0] ether_type   = '0;
    logic [31:0] type_pair    = '0;
    logic [15:0] size_pair    = '0;
    logic [15:0] opcode       = '0;
    logic [47:0] src_mac      = '0;
    logic [31:0] src_ip       = '0;
    logic [31:0] tgt_ip       = '0;
    logic [31:0] query_ip     = '0;
    logic [7:0]  entry_index  = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  status;
    logic        send_frame;
    logic [47:0] tx_dst_mac;
    logic [1:0]  tx_opcode;
    logic [47:0] tx_tgt_mac;
    logic [31:0] tx_tgt_ip;
    logic [31:0] found_ip;
    logic [47:0] found_mac;
    logic [8:0]  valid_entry_count;

    int          mismatches;
    int          outstanding;

    logic        calm = 1'b0;
    int unsigned stall_left = 0;
    int unsigned quiet_cycles = 0;
    logic [31:0] ip_pool [POOL_SIZE];
    logic [31:0] stim_local_ip = arpc_pkg::LOCAL_IP_RESET;

    arp_responder_with_cache_unit u_dut (.*);

    arp_cache_checker u_check (.*);

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver backpressure in random bursts
    always @(posedge clk) begin
        if (calm || !rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 12) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Count cycles without progress on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [47:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic logic [31:0] pool_ip();
        return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    function automatic arp_item_t noise_item();
        arp_item_t it;
        it.action       = 2'($urandom);
        it.frame_length = 11'($urandom);
        it.ether_type   = 16'($urandom);
        it.type_pair    = $urandom;
        it.size_pair    = 16'($urandom);
        it.opcode       = 16'($urandom);
        it.src_mac      = rand_mac();
        it.src_ip       = $urandom;
        it.tgt_ip       = $urandom;
        it.query_ip     = $urandom;
        it.entry_index  = 8'($urandom);
        return it;
    endfunction

    function automatic arp_item_t arp_frame(logic [15:0] op, logic [47:0] smac,
                                            logic [31:0] sip, logic [31:0] tip);
        arp_item_t it;
        it = noise_item();
        it.action       = arpc_pkg::ACT_FRAME;
        it.frame_length = 11'($urandom_range(arpc_pkg::MIN_FRAME_LEN, 2047));
        it.ether_type   = arpc_pkg::ETYPE_ARP;
        it.type_pair    = {arpc_pkg::HTYPE_ETHER, arpc_pkg::PTYPE_IPV4};
        it.size_pair    = arpc_pkg::SIZES_ETH_IPV4;
        it.opcode       = op;
        it.src_mac      = smac;
        it.src_ip       = sip;
        it.tgt_ip       = tip;
        return it;
    endfunction

    // Mostly well-formed frames over a small address pool, plus queries and noise
    function automatic arp_item_t random_item();
        arp_item_t   it;
        int unsigned pick;
        logic [15:0] op;
        logic [31:0] tip;
        it = noise_item();
        pick = $urandom_range(0, 99);
        op  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 2));
        tip = ($urandom_range(0, 1) == 1) ? stim_local_ip : pool_ip();
        if (pick < 55) begin
            it = arp_frame(op, rand_mac(), pool_ip(), tip);
            if ($urandom_range(0, 9) == 0)
                it.frame_length = arpc_pkg::MIN_FRAME_LEN;
        end else if (pick < 65) begin
            // break exactly one header check
            it = arp_frame(op, rand_mac(), pool_ip(), tip);
            case ($urandom_range(0, 4))
                0: it.frame_length = 11'($urandom_range(0, arpc_pkg::MIN_FRAME_LEN - 1));
                1: it.ether_type ^= 16'($urandom_range(1, 65535));
                2: it.type_pair[31:16] ^= 16'($urandom_range(1, 65535));
                3: it.type_pair[15:0] ^= 16'($urandom_range(1, 65535));
                default: it.size_pair ^= 16'($urandom_range(1, 65535));
            endcase
        end else if (pick < 78) begin
            it.action = arpc_pkg::ACT_LOOKUP;
            if ($urandom_range(0, 3) != 0)
                it.query_ip = pool_ip();
        end else if (pick < 90) begin
            it.action = arpc_pkg::ACT_READ;
            if ($urandom_range(0, 7) != 0)
                it.entry_index = 8'($urandom_range(0, 17));
        end else if (pick < 96) begin
            it.action = arpc_pkg::ACT_REQUEST;
        end
        return it;
    endfunction

    // Offer one request, hold it until accepted, then maybe idle
    task automatic send_item(input arp_item_t it);
        int unsigned n;
        action       <= it.action;
        frame_length <= it.frame_length;
        ether_type   <= it.ether_type;
        type_pair    <= it.type_pair;
        size_pair    <= it.size_pair;
        opcode       <= it.opcode;
        src_mac      <= it.src_mac;
        src_ip       <= it.src_ip;
        tgt_ip       <= it.tgt_ip;
        query_ip     <= it.query_ip;
        entry_index  <= it.entry_index;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!calm && $urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every predicted result to come back
    task automatic drain(input int unsigned settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] ip, input logic ip_ok,
                              input logic [47:0] mac, input logic ready);
        cfg_we    <= 1'b1;
        cfg_index <= arpc_pkg::CFG_LOCAL_IP;
        cfg_data  <= {16'h0, ip};
        @(posedge clk);
        cfg_index <= arpc_pkg::CFG_LOCAL_IP_VALID;
        cfg_data  <= {47'h0, ip_ok};
        @(posedge clk);
        cfg_index <= arpc_pkg::CFG_LOCAL_MAC;
        cfg_data  <= mac;
        @(posedge clk);
        cfg_index <= arpc_pkg::CFG_NIC_READY;
        cfg_data  <= {47'h0, ready};
        @(posedge clk);
        cfg_we <= 1'b0;
        stim_local_ip = ip;
    endtask

    initial begin
        arp_item_t it;

        for (int i = 0; i < POOL_SIZE; i++)
            ip_pool[i] = $urandom;
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        ip_pool[2] = arpc_pkg::LOCAL_IP_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty cache, interface down
        it = noise_item();
        it.action = arpc_pkg::ACT_LOOKUP;
        send_item(it);
        it = noise_item();
        it.action = arpc_pkg::ACT_READ;
        it.entry_index = 8'd0;
        send_item(it);
        it = noise_item();
        it.action = arpc_pkg::ACT_REQUEST;
        send_item(it);

        // short frames and each header check
        it = arp_frame(arpc_pkg::RX_OP_REQUEST, rand_mac(), $urandom,
                       arpc_pkg::LOCAL_IP_RESET);
        it.frame_length = 11'd0;
        send_item(it);
        it.frame_length = arpc_pkg::MIN_FRAME_LEN - 1;
        send_item(it);
        it.frame_length = arpc_pkg::MIN_FRAME_LEN;
        it.ether_type = 16'h0000;
        send_item(it);
        it.ether_type = arpc_pkg::ETYPE_ARP;
        it.type_pair = {16'hFFFF, arpc_pkg::PTYPE_IPV4};
        send_item(it);
        it.type_pair = {arpc_pkg::HTYPE_ETHER, 16'h0000};
        send_item(it);
        it.type_pair = {arpc_pkg::HTYPE_ETHER, arpc_pkg::PTYPE_IPV4};
        it.size_pair = 16'h0406;
        send_item(it);

        // learning: request to us while down, a reply, an update of the first sender
        send_item(arp_frame(arpc_pkg::RX_OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'h0,
                            arpc_pkg::LOCAL_IP_RESET));
        it = arp_frame(arpc_pkg::RX_OP_REPLY, 48'h0, 32'hFFFF_FFFF, 32'h0);
        it.frame_length = 11'h7FF;
        send_item(it);
        send_item(arp_frame(16'hFFFF, rand_mac(), 32'h0, 32'hFFFF_FFFF));

        // hit, miss, read in range and far beyond
        it = noise_item();
        it.action = arpc_pkg::ACT_LOOKUP;
        it.query_ip = 32'h0;
        send_item(it);
        it.query_ip = 32'h1234_5678;
        send_item(it);
        it.action = arpc_pkg::ACT_READ;
        it.entry_index = 8'd1;
        send_item(it);
        it.entry_index = 8'hFF;
        send_item(it);

        // interface up, own address withdrawn
        drain(SETTLE_CYCLES);
        set_config(32'hFFFF_FFFF, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b1);
        it = noise_item();
        it.action = arpc_pkg::ACT_REQUEST;
        send_item(it);
        send_item(arp_frame(arpc_pkg::RX_OP_REQUEST, rand_mac(), $urandom, 32'hFFFF_FFFF));

        // interface up, own address zero: reply and broadcast requests
        drain(SETTLE_CYCLES);
        set_config(32'h0, 1'b1, 48'h0123_4567_89AB, 1'b1);
        send_item(arp_frame(arpc_pkg::RX_OP_REQUEST, rand_mac(), $urandom, 32'h0));
        it = noise_item();
        it.action = arpc_pkg::ACT_REQUEST;
        it.query_ip = 32'hFFFF_FFFF;
        send_item(it);
        it.query_ip = 32'h0;
        send_item(it);

        // random phases over several register settings, the last one without idling
        for (int p = 0; p < 5; p++) begin
            drain(SETTLE_CYCLES);
            case (p)
                0: set_config(pool_ip(), 1'b1, rand_mac(), 1'b1);
                1: set_config(pool_ip(), 1'b1, rand_mac(), 1'b0);
                2: set_config(pool_ip(), 1'b0, rand_mac(), 1'b1);
                3: set_config(32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1);
                default: set_config(32'h0, 1'b1, 48'h0, 1'b1);
            endcase
            calm <= (p == 4) || ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS)
                send_item(random_item());
        end

        drain(SETTLE_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
